[src/csrsa_pkg.sv]
// shared types and constants for the sparse row scatter-accumulate store
package csrsa_pkg;

  localparam int FUNC_W   = 3;
  localparam int DOF_W    = 11;
  localparam int SLOT_W   = 15;
  localparam int VAL_W    = 32;
  localparam int ACC_W    = 48;
  localparam int POS_W    = 14;
  localparam int COL_W    = 10;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_ROW = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_COL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SKIP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ROW_A,
    S_ROW_B,
    S_SCAN,
    S_ACC_RD,
    S_ACC_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic row_a;
    logic row_b;
    logic scan;
    logic acc_rd;
    logic acc_upd;
    logic set_skip;
    logic set_miss;
    logic clr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic is_clear;
    logic skip;
    logic row_bad;
    logic hit;
    logic more;
    logic clr_last;
    logic out_busy;
  } stat_t;

endpackage

[src/csrsa_ram.sv]
// generic single-write single-read ram with registered read data
module csrsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/csrsa_ctrl.sv]
// controller state machine: sequences load, lookup, accumulate and clear
module csrsa_ctrl
  import csrsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   clear_reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clear_reply <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECODE && stat.is_clear) begin
        clear_reply <= 1'b1;
      end else if (state == S_CLEAR && stat.clr_last) begin
        clear_reply <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_last) begin
          state_next = clear_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_clear) begin
          state_next = S_CLEAR;
        end else if (stat.is_lookup && !stat.skip && !stat.row_bad) begin
          state_next = S_ROW_A;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ROW_A: state_next = S_ROW_B;
      S_ROW_B: state_next = S_SCAN;
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_ACC_RD;
        end else if (!stat.more) begin
          state_next = S_DONE;
        end
      end
      S_ACC_RD:  state_next = S_ACC_UPD;
      S_ACC_UPD: state_next = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.is_lookup) begin
          cmd.set_skip = stat.skip;
          cmd.set_miss = !stat.skip && stat.row_bad;
        end
      end
      S_ROW_A: cmd.row_a = 1'b1;
      S_ROW_B: cmd.row_b = 1'b1;
      S_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.set_miss = !stat.hit && !stat.more;
      end
      S_ACC_RD:  cmd.acc_rd = 1'b1;
      S_ACC_UPD: cmd.acc_upd = 1'b1;
      S_DONE:    cmd.out_load = !stat.out_busy;
      default:   cmd = '0;
    endcase
  end

  assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken while the clearing pass runs");

  assert property (@(posedge clk) disable iff (rst) state == S_ACC_RD |=> state == S_ACC_UPD)
    else $error("accumulator read not followed by update");

  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> !stat.out_busy)
    else $error("result loaded over one not yet taken");

endmodule

[src/csrsa_dp.sv]
// datapath: item registers, pattern and accumulator stores, scan and output register
module csrsa_dp
  import csrsa_pkg::*;
#(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_ENTRIES = 16384
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic [FUNC_W-1:0]          func,
  input  logic signed [DOF_W-1:0]    row_dof,
  input  logic signed [DOF_W-1:0]    col_dof,
  input  logic [SLOT_W-1:0]          slot,
  input  logic [SLOT_W-1:0]          load_word,
  input  logic signed [VAL_W-1:0]    entry_value,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic signed [ACC_W-1:0]    read_value,
  output logic [POS_W-1:0]           entry_position
);

  localparam int RS_DEPTH = MAX_ROWS + 1;
  localparam int RAW = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;
  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic                    upper_only;

  // item registers
  logic [FUNC_W-1:0]       func_q;
  logic signed [DOF_W-1:0] row_q;
  logic signed [DOF_W-1:0] col_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [SLOT_W-1:0]       word_q;
  logic signed [VAL_W-1:0] val_q;

  logic [SLOT_W-1:0]       scan_ptr;
  logic [SLOT_W-1:0]       scan_end;
  logic [SLOT_W-1:0]       pend_ptr;
  logic                    pend_valid;
  logic [EAW-1:0]          clr_ptr;

  logic [STATUS_W-1:0]     res_status;
  logic signed [ACC_W-1:0] res_value;
  logic [POS_W-1:0]        res_pos;

  logic                    rs_we;
  logic [RAW-1:0]          rs_raddr;
  logic [SLOT_W-1:0]       rs_rdata;
  logic                    ec_we;
  logic [COL_W-1:0]        ec_rdata;
  logic                    acc_we;
  logic [EAW-1:0]          acc_waddr;
  logic signed [ACC_W-1:0] acc_wdata;
  logic signed [ACC_W-1:0] acc_rdata;

  logic                    is_add;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sat;

  assign is_add = (func_q == FUNC_ADD);

  always_comb begin
    stat           = '0;
    stat.is_lookup = (func_q == FUNC_ADD) || (func_q == FUNC_READ);
    stat.is_clear  = (func_q == FUNC_CLEAR);
    stat.skip      = row_q[DOF_W-1] || col_q[DOF_W-1] || (upper_only && (col_q < row_q));
    stat.row_bad   = 32'(unsigned'(row_q)) >= 32'(MAX_ROWS);
    stat.hit       = pend_valid && (ec_rdata == col_q[COL_W-1:0]);
    stat.more      = (scan_ptr < scan_end) && (32'(scan_ptr) < 32'(MAX_ENTRIES));
    stat.clr_last  = 32'(clr_ptr) == 32'(MAX_ENTRIES - 1);
    stat.out_busy  = out_valid && !out_ready;
  end

  // saturating 48-bit accumulate
  assign sum = {acc_rdata[ACC_W-1], acc_rdata} + (ACC_W+1)'(val_q);
  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_only <= 1'b1;
    end else if (cfg_wr_en) begin
      upper_only <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      row_q  <= row_dof;
      col_q  <= col_dof;
      slot_q <= slot;
      word_q <= load_word;
      val_q  <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      clr_ptr    <= '0;
    end else begin
      if (cmd.row_b) begin
        pend_valid <= 1'b0;
      end else if (cmd.scan && !stat.hit) begin
        pend_valid <= stat.more;
      end
      if (cmd.clr_step) begin
        clr_ptr <= stat.clr_last ? '0 : clr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_a) begin
      scan_ptr <= rs_rdata;
    end else if (cmd.scan && !stat.hit && stat.more) begin
      scan_ptr <= scan_ptr + 1'b1;
    end
    if (cmd.row_b) begin
      scan_end <= rs_rdata;
    end
    if (cmd.scan && !stat.hit && stat.more) begin
      pend_ptr <= scan_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status <= ST_DONE;
      res_value  <= '0;
      res_pos    <= '0;
    end else begin
      if (cmd.set_skip) begin
        res_status <= ST_SKIP;
      end else if (cmd.set_miss) begin
        res_status <= ST_MISS;
      end
      if (cmd.acc_upd) begin
        res_value <= is_add ? sat : acc_rdata;
        res_pos   <= POS_W'(pend_ptr);
      end
    end
  end

  // output register frees the core for the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      read_value     <= res_value;
      entry_position <= res_pos;
    end
  end

  assign rs_we    = cmd.decode && (func_q == FUNC_LOAD_ROW) &&
                    (32'(slot_q) <= 32'(MAX_ROWS));
  assign rs_raddr = cmd.row_a ? RAW'(unsigned'(row_q)) + RAW'(1) : RAW'(unsigned'(row_q));
  assign ec_we    = cmd.decode && (func_q == FUNC_LOAD_COL) &&
                    (32'(slot_q) < 32'(MAX_ENTRIES));

  assign acc_we    = cmd.clr_step || (cmd.acc_upd && is_add);
  assign acc_waddr = cmd.clr_step ? clr_ptr : EAW'(pend_ptr);
  assign acc_wdata = cmd.clr_step ? '0 : sat;

  csrsa_ram #(.WIDTH(SLOT_W), .DEPTH(RS_DEPTH)) u_row_start (
    .clk   (clk),
    .we    (rs_we),
    .waddr (RAW'(slot_q)),
    .wdata (word_q),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  csrsa_ram #(.WIDTH(COL_W), .DEPTH(MAX_ENTRIES)) u_entry_column (
    .clk   (clk),
    .we    (ec_we),
    .waddr (EAW'(slot_q)),
    .wdata (word_q[COL_W-1:0]),
    .raddr (EAW'(scan_ptr)),
    .rdata (ec_rdata)
  );

  csrsa_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ENTRIES)) u_accumulated (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (EAW'(pend_ptr)),
    .rdata (acc_rdata)
  );

  assert property (@(posedge clk) disable iff (rst)
      out_valid && (status == ST_MISS || status == ST_SKIP) |->
      read_value == '0 && entry_position == '0)
    else $error("result without a hit carries a value or position");

  assert property (@(posedge clk) disable iff (rst)
      cmd.acc_upd |-> $past(cmd.acc_rd) && $stable(pend_ptr))
    else $error("accumulator update without a matching read");

  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(read_value) && $stable(entry_position))
    else $error("waiting result changed before it was taken");

endmodule

[src/sparse_csr_scatter_accumulate_core.sv]
// top level of the sparse row scatter-accumulate store
// steps, accepting edge to out_valid: loads, skips, bad rows and unused codes go from decode
//   to done; add and read go on through the row-start reads and a scan of the row (one entry
//   compared per cycle) to the accumulator read and update, a miss ends at the scan; clear
//   zeroes one accumulator per cycle; one item in work at a time, the next taken in the cycle
//   after the result is loaded into the output register, which holds it while out_ready is low
// reset: synchronous; a clearing pass zeroes all MAX_ENTRIES accumulators, in_ready low
module sparse_csr_scatter_accumulate_core
  import csrsa_pkg::*;
#(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_ENTRIES = 16384
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       func,
  input  logic signed [DOF_W-1:0] row_dof,
  input  logic signed [DOF_W-1:0] col_dof,
  input  logic [SLOT_W-1:0]       slot,
  input  logic [SLOT_W-1:0]       load_word,
  input  logic signed [VAL_W-1:0] entry_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic signed [ACC_W-1:0] read_value,
  output logic [POS_W-1:0]        entry_position
);

  cmd_t  cmd;
  stat_t stat;

  csrsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csrsa_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .func           (func),
    .row_dof        (row_dof),
    .col_dof        (col_dof),
    .slot           (slot),
    .load_word      (load_word),
    .entry_value    (entry_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .read_value     (read_value),
    .entry_position (entry_position)
  );

endmodule
